FILE: src/idll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

  localparam int CAPACITY    = 64;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int VALUE_WIDTH = 32;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   used;
    slot_t  lnk_prev;
    slot_t  lnk_next;
    value_t val;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  function automatic cell_t reset_cell(input slot_t idx);
    cell_t c;
    c.used     = (idx == '0);
    c.lnk_prev = '0;
    c.val      = '0;
    if (idx == '0 || idx == slot_t'(CAPACITY - 1)) begin
      c.lnk_next = '0;
    end else begin
      c.lnk_next = idx + slot_t'(1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/idll_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/indexed_doubly_linked_list_engine_core.sv
// Flow: a read or a rejected operation goes from S_AT to S_DONE, which loads the
// outputs and raises out_valid; an insert or a remove first runs read-modify-write
// passes through the cell store (one registered read and one write per cycle) in
// S_FR/S_WA/S_RD/S_WR. A new operation waits until S_DONE, held by out_stall, ends.
// Reset: per-cell valid bits make every cell read as its reset contents until first
// written, so the list comes up empty with every cell but sentinel cell 0 free.
`timescale 1ns / 1ps
`default_nettype none

module indexed_doubly_linked_list_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  slot_index,
  input  wire logic [31:0] data_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       result_slot,
  output logic [31:0]      read_value,
  output logic [5:0]       next_link,
  output logic [5:0]       prev_link,
  output logic             slot_used,
  output logic [5:0]       head_slot,
  output logic [5:0]       tail_slot,
  output logic [5:0]       element_count
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AT   = 3'd1;
  localparam logic [2:0] S_FR   = 3'd2;
  localparam logic [2:0] S_WA   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;

  logic [idll_pkg::CAPACITY-1:0] cell_vld;
  idll_pkg::slot_t  free_head;
  idll_pkg::slot_t  head_reg;
  idll_pkg::slot_t  tail_reg;
  idll_pkg::slot_t  count_reg;

  logic [1:0]       op_kind;
  idll_pkg::slot_t  op_at;
  idll_pkg::value_t op_val;
  idll_pkg::cell_t  at_cell;
  idll_pkg::slot_t  fresh;

  idll_pkg::slot_t  tgt_addr;
  logic             tgt_prev;
  idll_pkg::slot_t  tgt_val;
  logic             chain;

  logic [1:0]       res_status;
  idll_pkg::slot_t  res_slot;
  idll_pkg::cell_t  res_cell;

  idll_pkg::slot_t  rd_addr;
  idll_pkg::slot_t  rd_addr_q;
  logic [idll_pkg::CELL_W-1:0] rd_q;
  idll_pkg::cell_t  cur;

  logic             we;
  idll_pkg::slot_t  wa;
  idll_pkg::cell_t  wd;
  idll_pkg::cell_t  mod_cell;
  logic             load_out;

  idll_ram #(
    .WIDTH(idll_pkg::CELL_W),
    .DEPTH(idll_pkg::CAPACITY)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(wa),
    .wdata(wd),
    .raddr(rd_addr),
    .rdata(rd_q)
  );

  assign in_stall = (state != S_IDLE);
  assign cur      = cell_vld[rd_addr_q] ? idll_pkg::cell_t'(rd_q)
                                        : idll_pkg::reset_cell(rd_addr_q);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = slot_index;
      S_AT:    rd_addr = free_head;
      S_RD:    rd_addr = tgt_addr;
      default: rd_addr = rd_addr_q;
    endcase
  end

  always_comb begin
    mod_cell = cur;
    if (tgt_prev) begin
      mod_cell.lnk_prev = tgt_val;
    end else begin
      mod_cell.lnk_next = tgt_val;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = rd_addr_q;
    wd = cur;
    case (state)
      S_AT: begin
        wa = op_at;
        wd = '{used: 1'b0, lnk_prev: '0, lnk_next: free_head, val: '0};
        we = (op_kind == idll_pkg::KIND_REMOVE) && (op_at != '0) && cur.used;
      end
      S_FR: begin
        we = 1'b1;
        wa = rd_addr_q;
        wd = '{used: 1'b1, lnk_prev: op_at, lnk_next: at_cell.lnk_next, val: op_val};
      end
      S_WA: begin
        we          = 1'b1;
        wa          = op_at;
        wd          = at_cell;
        wd.lnk_next = fresh;
      end
      S_WR: begin
        we = 1'b1;
        wa = rd_addr_q;
        wd = mod_cell;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (rst) begin
      state     <= S_IDLE;
      cell_vld  <= '0;
      free_head <= idll_pkg::slot_t'(1);
      head_reg  <= '0;
      tail_reg  <= '0;
      count_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (we) begin
        cell_vld[wa] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind <= kind;
            op_at   <= slot_index;
            op_val  <= data_value;
            state   <= S_AT;
          end
        end
        S_AT: begin
          at_cell    <= cur;
          res_status <= idll_pkg::ST_BAD;
          res_slot   <= '0;
          res_cell   <= '0;
          state      <= S_DONE;
          case (op_kind)
            idll_pkg::KIND_READ: begin
              res_status <= idll_pkg::ST_OK;
              res_slot   <= op_at;
              res_cell   <= cur;
            end
            idll_pkg::KIND_INSERT: begin
              if (cur.used && free_head == '0) begin
                res_status <= idll_pkg::ST_FULL;
              end else if (cur.used) begin
                state <= S_FR;
              end
            end
            idll_pkg::KIND_REMOVE: begin
              if (op_at != '0 && cur.used) begin
                free_head  <= op_at;
                count_reg  <= count_reg - idll_pkg::slot_t'(1);
                if (cur.lnk_prev == '0) begin
                  head_reg <= cur.lnk_next;
                end
                if (cur.lnk_next == '0) begin
                  tail_reg <= cur.lnk_prev;
                end
                tgt_addr   <= cur.lnk_prev;
                tgt_prev   <= 1'b0;
                tgt_val    <= cur.lnk_next;
                chain      <= 1'b1;
                res_status <= idll_pkg::ST_OK;
                res_slot   <= op_at;
                state      <= S_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_FR: begin
          fresh      <= rd_addr_q;
          free_head  <= cur.lnk_next;
          count_reg  <= count_reg + idll_pkg::slot_t'(1);
          if (at_cell.lnk_next == '0) begin
            tail_reg <= rd_addr_q;
          end
          if (op_at == '0) begin
            head_reg <= rd_addr_q;
          end
          res_status <= idll_pkg::ST_OK;
          res_slot   <= rd_addr_q;
          state      <= S_WA;
        end
        S_WA: begin
          tgt_addr <= at_cell.lnk_next;
          tgt_prev <= 1'b1;
          tgt_val  <= fresh;
          chain    <= 1'b0;
          state    <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (chain) begin
            tgt_addr <= at_cell.lnk_next;
            tgt_prev <= 1'b1;
            tgt_val  <= at_cell.lnk_prev;
            chain    <= 1'b0;
            state    <= S_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      result_slot   <= res_slot;
      read_value    <= res_cell.val;
      next_link     <= res_cell.lnk_next;
      prev_link     <= res_cell.lnk_prev;
      slot_used     <= res_cell.used;
      head_slot     <= head_reg;
      tail_slot     <= tail_reg;
      element_count <= count_reg;
    end
  end

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
    else $error("empty list with nonzero head or tail");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head_reg == '0) == (tail_reg == '0))
    else $error("head and tail disagree on emptiness");

  a_free_full: assert property (@(posedge clk) disable iff (rst)
    (free_head == '0) |-> (count_reg == idll_pkg::slot_t'(idll_pkg::CAPACITY - 1)))
    else $error("free list empty while cells remain");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result dropped while output stalled");

  a_no_sentinel_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FR) |-> (rd_addr_q != '0))
    else $error("sentinel taken from free list");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    idll_pkg::slot_t  slot;
    idll_pkg::value_t value;
    idll_pkg::slot_t  nxt;
    idll_pkg::slot_t  prv;
    logic             used;
    idll_pkg::slot_t  head;
    idll_pkg::slot_t  tail;
    idll_pkg::slot_t  count;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [5:0]  slot_index;
  logic [31:0] data_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [5:0]  result_slot;
  logic [31:0] read_value;
  logic [5:0]  next_link;
  logic [5:0]  prev_link;
  logic        slot_used;
  logic [5:0]  head_slot;
  logic [5:0]  tail_slot;
  logic [5:0]  element_count;

  indexed_doubly_linked_list_engine_core DUT (.*);

  idll_pkg::slot_t  nxt_q [idll_pkg::CAPACITY];
  idll_pkg::slot_t  prv_q [idll_pkg::CAPACITY];
  logic             used_q [idll_pkg::CAPACITY];
  idll_pkg::value_t val_q [idll_pkg::CAPACITY];
  idll_pkg::slot_t  free_q;
  idll_pkg::slot_t  head_q;
  idll_pkg::slot_t  tail_q;
  idll_pkg::slot_t  count_q;

  list_result_t pending_results [$];
  int           mismatches = 0;
  logic         gaps_on;

  function automatic void reset_list_model();
    for (int i = 0; i < idll_pkg::CAPACITY; i++) begin
      nxt_q[i]  = (i == 0 || i == idll_pkg::CAPACITY - 1) ? idll_pkg::slot_t'(0)
                                                         : idll_pkg::slot_t'(i + 1);
      prv_q[i]  = '0;
      used_q[i] = (i == 0);
      val_q[i]  = '0;
    end
    free_q  = idll_pkg::slot_t'(1);
    head_q  = '0;
    tail_q  = '0;
    count_q = '0;
  endfunction

  function automatic list_result_t apply_list_op(logic [1:0] op, idll_pkg::slot_t pos,
                                                 idll_pkg::value_t v);
    list_result_t    r;
    idll_pkg::slot_t fresh;
    idll_pkg::slot_t succ;
    idll_pkg::slot_t p;
    idll_pkg::slot_t n;
    r = '0;
    case (op)
      idll_pkg::KIND_INSERT: begin
        if (!used_q[pos]) begin
          r.status = idll_pkg::ST_BAD;
        end else if (free_q == '0) begin
          r.status = idll_pkg::ST_FULL;
        end else begin
          fresh        = free_q;
          free_q       = nxt_q[fresh];
          succ         = nxt_q[pos];
          val_q[fresh] = v;
          prv_q[fresh] = pos;
          nxt_q[fresh] = succ;
          prv_q[succ]  = fresh;
          nxt_q[pos]   = fresh;
          used_q[fresh] = 1'b1;
          count_q++;
          if (succ == '0) tail_q = fresh;
          if (pos == '0) head_q = fresh;
          r.status = idll_pkg::ST_OK;
          r.slot   = fresh;
        end
      end
      idll_pkg::KIND_REMOVE: begin
        if (pos == '0 || !used_q[pos]) begin
          r.status = idll_pkg::ST_BAD;
        end else begin
          p = prv_q[pos];
          n = nxt_q[pos];
          if (p == '0) head_q = n;
          if (n == '0) tail_q = p;
          val_q[pos]  = '0;
          nxt_q[p]    = n;
          prv_q[n]    = p;
          nxt_q[pos]  = free_q;
          prv_q[pos]  = '0;
          used_q[pos] = 1'b0;
          free_q      = pos;
          count_q--;
          r.status = idll_pkg::ST_OK;
          r.slot   = pos;
        end
      end
      idll_pkg::KIND_READ: begin
        r.status = idll_pkg::ST_OK;
        r.slot   = pos;
        r.value  = val_q[pos];
        r.nxt    = nxt_q[pos];
        r.prv    = prv_q[pos];
        r.used   = used_q[pos];
      end
      default: r.status = idll_pkg::ST_BAD;
    endcase
    r.head  = head_q;
    r.tail  = tail_q;
    r.count = count_q;
    return r;
  endfunction

  function automatic idll_pkg::slot_t walk_from_head(int unsigned steps);
    idll_pkg::slot_t s;
    s = head_q;
    repeat (steps) s = nxt_q[s];
    return s;
  endfunction

  // sentinel or any element
  function automatic idll_pkg::slot_t pick_anchor();
    int unsigned k;
    k = $urandom_range(0, count_q);
    return (k == 0) ? idll_pkg::slot_t'(0) : walk_from_head(k - 1);
  endfunction

  function automatic idll_pkg::slot_t pick_member();
    if (count_q == '0) return idll_pkg::slot_t'($urandom_range(0, idll_pkg::CAPACITY - 1));
    return walk_from_head($urandom_range(0, count_q - 1));
  endfunction

  function automatic string fmt_result(list_result_t r);
    return {$sformatf("st=%0d slot=%0d val=%h next=%0d prev=%0d ",
                      r.status, r.slot, r.value, r.nxt, r.prv),
            $sformatf("used=%0b head=%0d tail=%0d cnt=%0d",
                      r.used, r.head, r.tail, r.count)};
  endfunction

  task automatic send_op(input logic [1:0] op, input idll_pkg::slot_t pos,
                         input idll_pkg::value_t v);
    if (gaps_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 24);
    end
    kind       <= op;
    slot_index <= pos;
    data_value <= v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_list_op(op, pos, v));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_list();
    send_op(idll_pkg::KIND_READ, 6'd0, '0);
    send_op(idll_pkg::KIND_READ, 6'd1, '0);
    send_op(idll_pkg::KIND_READ, 6'd63, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd0, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd5, '0);
    send_op(idll_pkg::KIND_INSERT, 6'd9, 32'h7FFF_FFFF);
    send_op(KIND_UNDEFINED, 6'd0, '0);
    drain_results();
  endtask

  task automatic test_insert_remove();
    send_op(idll_pkg::KIND_INSERT, 6'd0, 32'h7FFF_FFFF);
    send_op(idll_pkg::KIND_INSERT, 6'd0, 32'h8000_0000);
    send_op(idll_pkg::KIND_INSERT, 6'd1, 32'hFFFF_FFFF);
    send_op(idll_pkg::KIND_INSERT, 6'd2, 32'h0000_0000);
    send_op(idll_pkg::KIND_READ, 6'd2, '0);
    send_op(idll_pkg::KIND_READ, 6'd4, '0);
    send_op(idll_pkg::KIND_READ, 6'd0, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd4, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd2, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd3, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd1, '0);
    send_op(idll_pkg::KIND_READ, 6'd3, '0);
    send_op(idll_pkg::KIND_READ, 6'd1, '0);
    send_op(idll_pkg::KIND_REMOVE, 6'd3, '0);
    send_op(idll_pkg::KIND_INSERT, 6'd3, 32'h1234_5678);
    send_op(KIND_UNDEFINED, 6'd63, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_fill_and_drain();
    while (free_q != '0) send_op(idll_pkg::KIND_INSERT, pick_anchor(), $urandom());
    send_op(idll_pkg::KIND_INSERT, pick_anchor(), $urandom());
    send_op(idll_pkg::KIND_READ, 6'd63, '0);
    send_op(idll_pkg::KIND_READ, 6'd0, '0);
    while (count_q != '0) send_op(idll_pkg::KIND_REMOVE, pick_member(), $urandom());
    send_op(idll_pkg::KIND_REMOVE, 6'd1, '0);
    send_op(idll_pkg::KIND_READ, 6'd0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_ops);
    int unsigned roll;
    int unsigned ins_w;
    for (int unsigned i = 0; i < n_ops; i++) begin
      gaps_on = !(i >= n_ops / 3 && i < n_ops / 3 + 120);
      ins_w   = ((i / 50) % 2 == 0) ? 55 : 20;
      roll    = $urandom_range(0, 99);
      if (roll < 8) begin
        send_op(2'($urandom_range(0, 3)),
                idll_pkg::slot_t'($urandom_range(0, idll_pkg::CAPACITY - 1)), $urandom());
      end else if (roll < 8 + ins_w) begin
        send_op(idll_pkg::KIND_INSERT, pick_anchor(), $urandom());
      end else if (roll < 78) begin
        send_op(idll_pkg::KIND_REMOVE, pick_member(), $urandom());
      end else begin
        send_op(idll_pkg::KIND_READ,
                idll_pkg::slot_t'($urandom_range(0, idll_pkg::CAPACITY - 1)), $urandom());
      end
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 24);
  end

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    string        bad;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, result_slot, read_value, next_link, prev_link, slot_used,
              head_slot, tail_slot, element_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.slot !== want.slot) bad = {bad, " result_slot"};
        if (got.value !== want.value) bad = {bad, " read_value"};
        if (got.nxt !== want.nxt) bad = {bad, " next_link"};
        if (got.prv !== want.prv) bad = {bad, " prev_link"};
        if (got.used !== want.used) bad = {bad, " slot_used"};
        if (got.head !== want.head) bad = {bad, " head_slot"};
        if (got.tail !== want.tail) bad = {bad, " tail_slot"};
        if (got.count !== want.count) bad = {bad, " element_count"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch in%s", bad);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = idll_pkg::KIND_READ;
    slot_index = '0;
    data_value = '0;
    out_stall  = 1'b0;
    gaps_on    = 1'b1;
    reset_list_model();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_insert_remove();
    test_fill_and_drain();
    test_random_traffic(450);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
